// ===== src/vtp_pkg.sv =====
package vtp_pkg;

  localparam int HALF_BITS = 11;
  localparam int SCREEN_BITS = 16;
  localparam int SAT_LIM = 32767;
  localparam int QUOT_BITS = 17;
  localparam int APB_DATA_BITS = 64;
  localparam int APB_ADDR_BITS = 6;

  typedef enum logic [2:0] {
    REG_LIN_ROW_X   = 3'd0,
    REG_LIN_ROW_Y   = 3'd1,
    REG_LIN_ROW_Z   = 3'd2,
    REG_TRANS_X     = 3'd3,
    REG_TRANS_Y     = 3'd4,
    REG_TRANS_Z     = 3'd5,
    REG_HALF_WIDTH  = 3'd6,
    REG_HALF_HEIGHT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [HALF_BITS-1:0] half_width;
    logic [HALF_BITS-1:0] half_height;
  } view_cfg_t;

endpackage

// ===== src/vtp_if.sv =====
interface vtp_vert_if #(parameter int COORD_BITS = 32);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] vert_x;
  logic signed [COORD_BITS-1:0] vert_y;
  logic signed [COORD_BITS-1:0] vert_z;
  modport source (output valid, vert_x, vert_y, vert_z, input ready);
  modport sink (input valid, vert_x, vert_y, vert_z, output ready);
endinterface

interface vtp_screen_if;
  logic valid;
  logic ready;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic behind_eye;
  modport source (output valid, screen_x, screen_y, behind_eye, input ready);
  modport sink (input valid, screen_x, screen_y, behind_eye, output ready);
endinterface

// ===== src/vtp_regs.sv =====
module vtp_regs #(
  parameter int COORD_BITS = 32,
  parameter int COEF_BITS = 16,
  parameter int LIN_W = 48
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [vtp_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [vtp_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [vtp_pkg::APB_DATA_BITS-1:0] prdata,
  output logic pready,
  output logic [LIN_W-1:0] lin_x,
  output logic [LIN_W-1:0] lin_y,
  output logic [LIN_W-1:0] lin_z,
  output logic [COORD_BITS-1:0] trans_x,
  output logic [COORD_BITS-1:0] trans_y,
  output logic [COORD_BITS-1:0] trans_z,
  output vtp_pkg::view_cfg_t view
);
  import vtp_pkg::*;

  localparam int CW = 3 * COEF_BITS;
  localparam logic [CW-1:0] ONE_X = CW'(1) << (COEF_BITS - 2);
  localparam logic [CW-1:0] ONE_Y = ONE_X << COEF_BITS;
  localparam logic [CW-1:0] ONE_Z = ONE_Y << COEF_BITS;
  localparam logic [COORD_BITS-1:0] TZ_RESET = COORD_BITS'(64'd20 << 16);

  logic wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  assign idx = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      lin_x <= LIN_W'(ONE_X);
      lin_y <= LIN_W'(ONE_Y);
      lin_z <= LIN_W'(ONE_Z);
      trans_x <= '0;
      trans_y <= '0;
      trans_z <= TZ_RESET;
      view.half_width <= HALF_BITS'(320);
      view.half_height <= HALF_BITS'(240);
    end else if (wr) begin
      case (idx)
        REG_LIN_ROW_X:   lin_x <= LIN_W'(pwdata);
        REG_LIN_ROW_Y:   lin_y <= LIN_W'(pwdata);
        REG_LIN_ROW_Z:   lin_z <= LIN_W'(pwdata);
        REG_TRANS_X:     trans_x <= COORD_BITS'(pwdata);
        REG_TRANS_Y:     trans_y <= COORD_BITS'(pwdata);
        REG_TRANS_Z:     trans_z <= COORD_BITS'(pwdata);
        REG_HALF_WIDTH:  view.half_width <= pwdata[HALF_BITS-1:0];
        REG_HALF_HEIGHT: view.half_height <= pwdata[HALF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LIN_ROW_X:   prdata = APB_DATA_BITS'(lin_x);
      REG_LIN_ROW_Y:   prdata = APB_DATA_BITS'(lin_y);
      REG_LIN_ROW_Z:   prdata = APB_DATA_BITS'(lin_z);
      REG_TRANS_X:     prdata = APB_DATA_BITS'(trans_x);
      REG_TRANS_Y:     prdata = APB_DATA_BITS'(trans_y);
      REG_TRANS_Z:     prdata = APB_DATA_BITS'(trans_z);
      REG_HALF_WIDTH:  prdata = APB_DATA_BITS'(view.half_width);
      REG_HALF_HEIGHT: prdata = APB_DATA_BITS'(view.half_height);
      default:         prdata = '0;
    endcase
  end
endmodule

// ===== src/vtp_eye.sv =====
module vtp_eye #(
  parameter int COORD_BITS = 32,
  parameter int COEF_BITS = 16,
  parameter int LIN_W = 48,
  parameter int EYE_W = 37
) (
  input  logic clk,
  input  logic rst,
  input  logic ce,
  input  logic in_valid,
  input  logic signed [COORD_BITS-1:0] vx,
  input  logic signed [COORD_BITS-1:0] vy,
  input  logic signed [COORD_BITS-1:0] vz,
  input  logic [LIN_W-1:0] lin_x,
  input  logic [LIN_W-1:0] lin_y,
  input  logic [LIN_W-1:0] lin_z,
  input  logic [COORD_BITS-1:0] trans_x,
  input  logic [COORD_BITS-1:0] trans_y,
  input  logic [COORD_BITS-1:0] trans_z,
  output logic out_valid,
  output logic signed [EYE_W-1:0] ex,
  output logic signed [EYE_W-1:0] ey,
  output logic signed [EYE_W-1:0] ez
);
  localparam int CW = 3 * COEF_BITS;
  localparam int PW = COORD_BITS + COEF_BITS;
  localparam int SUM_W = PW + 2;
  localparam int F = COEF_BITS - 2;

  logic [CW-1:0] row [3];
  logic signed [COORD_BITS-1:0] vin [3];
  logic signed [COORD_BITS-1:0] tr [3];
  logic signed [PW-1:0] prod [3][3];
  logic signed [EYE_W-1:0] eye [3];
  logic signed [SUM_W-1:0] sum [3];
  logic signed [SUM_W-1:0] shr [3];
  logic v1;

  assign row[0] = CW'(lin_x);
  assign row[1] = CW'(lin_y);
  assign row[2] = CW'(lin_z);
  assign vin[0] = vx;
  assign vin[1] = vy;
  assign vin[2] = vz;
  assign tr[0] = trans_x;
  assign tr[1] = trans_y;
  assign tr[2] = trans_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r][k] <= PW'(vin[k]) * PW'($signed(row[r][k*COEF_BITS +: COEF_BITS]));
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2]);
      shr[r] = sum[r] >>> F;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        eye[r] <= EYE_W'(shr[r]) + EYE_W'(tr[r]);
      end
    end
  end

  assign ex = eye[0];
  assign ey = eye[1];
  assign ez = eye[2];
endmodule

// ===== src/vtp_proj.sv =====
module vtp_proj #(
  parameter int EYE_W = 37
) (
  input  logic clk,
  input  logic rst,
  input  logic ce,
  input  logic in_valid,
  input  logic signed [EYE_W-1:0] ex,
  input  logic signed [EYE_W-1:0] ey,
  input  logic signed [EYE_W-1:0] ez,
  input  vtp_pkg::view_cfg_t view,
  output logic out_valid,
  output logic signed [vtp_pkg::SCREEN_BITS-1:0] sx,
  output logic signed [vtp_pkg::SCREEN_BITS-1:0] sy,
  output logic behind
);
  import vtp_pkg::*;

  localparam int QB = QUOT_BITS;
  localparam int MAG_W = EYE_W + HALF_BITS;
  localparam int RW = QB + 4;

  typedef struct packed {
    logic [EYE_W-1:0] rem;
    logic [QB-1:0] lo;
    logic [QB-1:0] q;
    logic neg;
    logic ovf;
  } lane_t;

  logic p0_v, p1_v, p2_v;
  logic p0_b, p1_b, p2_b;
  logic [EYE_W-2:0] p0_d, p1_d, p2_d;
  logic p0_neg [2];
  logic p1_neg [2];
  logic [EYE_W-1:0] p0_mag [2];
  logic [MAG_W-1:0] p1_mag [2];

  logic st_v [QB+1];
  logic st_b [QB+1];
  logic [EYE_W-2:0] st_d [QB+1];
  lane_t st [QB+1][2];

  logic signed [RW-1:0] res [2];
  logic [HALF_BITS-1:0] centre [2];

  assign centre[0] = view.half_width;
  assign centre[1] = view.half_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
      p1_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      p0_v <= in_valid;
      p1_v <= p0_v;
      out_valid <= st_v[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p0_b <= (ez[EYE_W-1] == 1'b1) || (ez == '0);
      p0_d <= ez[EYE_W-2:0];
      p0_neg[0] <= ex[EYE_W-1];
      p0_mag[0] <= ex[EYE_W-1] ? EYE_W'(-ex) : EYE_W'(ex);
      p0_neg[1] <= !ey[EYE_W-1] && (ey != '0);
      p0_mag[1] <= ey[EYE_W-1] ? EYE_W'(-ey) : EYE_W'(ey);

      p1_b <= p0_b;
      p1_d <= p0_d;
      for (int l = 0; l < 2; l++) begin
        p1_neg[l] <= p0_neg[l];
        p1_mag[l] <= MAG_W'(p0_mag[l]) * MAG_W'(view.half_height);
      end
    end
  end

  assign p2_v = p1_v;
  assign p2_b = p1_b;
  assign p2_d = p1_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else if (ce) begin
      st_v[0] <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      st_b[0] <= p2_b;
      st_d[0] <= p2_d;
      for (int l = 0; l < 2; l++) begin
        st[0][l].ovf <= (p1_mag[l] >> QB) >= MAG_W'(p2_d);
        st[0][l].rem <= EYE_W'(p1_mag[l] >> QB);
        st[0][l].lo <= p1_mag[l][QB-1:0];
        st[0][l].q <= '0;
        st[0][l].neg <= p1_neg[l];
      end
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [EYE_W:0] t [2];
    logic ge [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        t[l] = {st[s][l].rem, st[s][l].lo[QB-1]};
        ge[l] = t[l] >= (EYE_W+1)'(st_d[s]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[s+1] <= 1'b0;
      end else if (ce) begin
        st_v[s+1] <= st_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        st_b[s+1] <= st_b[s];
        st_d[s+1] <= st_d[s];
        for (int l = 0; l < 2; l++) begin
          st[s+1][l].rem <= ge[l] ? EYE_W'(t[l] - (EYE_W+1)'(st_d[s])) : EYE_W'(t[l]);
          st[s+1][l].lo <= st[s][l].lo << 1;
          st[s+1][l].q <= {st[s][l].q[QB-2:0], ge[l]};
          st[s+1][l].neg <= st[s][l].neg;
          st[s+1][l].ovf <= st[s][l].ovf;
        end
      end
    end
  end

  always_comb begin
    logic signed [RW-1:0] qv, rf, fl, cl, c, a, r;
    for (int l = 0; l < 2; l++) begin
      qv = st[QB][l].ovf ? (RW'(1) <<< QB) : RW'(st[QB][l].q);
      rf = RW'(st[QB][l].rem != '0);
      c = RW'(centre[l]);
      fl = st[QB][l].neg ? -qv - rf : qv;
      cl = st[QB][l].neg ? -qv : qv + rf;
      a = fl + c;
      r = a[RW-1] ? cl + c : a;
      if (r > RW'(SAT_LIM)) begin
        r = RW'(SAT_LIM);
      end else if (r < -RW'(SAT_LIM)) begin
        r = -RW'(SAT_LIM);
      end
      res[l] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      behind <= st_b[QB];
      sx <= st_b[QB] ? '0 : SCREEN_BITS'(res[0]);
      sy <= st_b[QB] ? '0 : SCREEN_BITS'(res[1]);
    end
  end
endmodule

// ===== src/vertex_transform_project.sv =====
// Transforms one model vertex per clock into screen coordinates: an affine 3x4 matrix
// gives eye x, y and z, then x and y are divided by depth over the half screen height,
// offset to the screen centre with y flipped, truncated toward zero and saturated to
// plus or minus 32767. A vertex at or behind the eye is flagged and returns zeros. The
// pipeline accepts one word per cycle. Its stages in order are the matrix multiply and
// sum, the absolute value, projection scale multiply and range check, the restoring
// divider that retires one quotient bit per stage, and the centre offset and saturation.
// When the result word is not taken, the whole pipeline holds and input ready drops in
// the same cycle.
module vertex_transform_project #(
  parameter int COORD_BITS = 32,
  parameter int COEF_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  vtp_vert_if.sink vin,
  vtp_screen_if.source vout,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [vtp_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [vtp_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [vtp_pkg::APB_DATA_BITS-1:0] prdata,
  output logic pready
);
  import vtp_pkg::*;

  localparam int LIN_W = (3 * COEF_BITS > APB_DATA_BITS) ? APB_DATA_BITS : 3 * COEF_BITS;
  localparam int EYE_W = COORD_BITS + 5;

  logic ce;
  logic [LIN_W-1:0] lin_x, lin_y, lin_z;
  logic [COORD_BITS-1:0] trans_x, trans_y, trans_z;
  view_cfg_t view;
  logic eye_valid;
  logic signed [EYE_W-1:0] ex, ey, ez;

  assign ce = !vout.valid || vout.ready;
  assign vin.ready = ce;

  vtp_regs #(.COORD_BITS(COORD_BITS), .COEF_BITS(COEF_BITS), .LIN_W(LIN_W)) u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .lin_x(lin_x), .lin_y(lin_y), .lin_z(lin_z),
    .trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z), .view(view)
  );

  vtp_eye #(.COORD_BITS(COORD_BITS), .COEF_BITS(COEF_BITS), .LIN_W(LIN_W),
            .EYE_W(EYE_W)) u_eye (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(vin.valid),
    .vx(vin.vert_x), .vy(vin.vert_y), .vz(vin.vert_z),
    .lin_x(lin_x), .lin_y(lin_y), .lin_z(lin_z),
    .trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z),
    .out_valid(eye_valid), .ex(ex), .ey(ey), .ez(ez)
  );

  vtp_proj #(.EYE_W(EYE_W)) u_proj (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(eye_valid),
    .ex(ex), .ey(ey), .ez(ez), .view(view),
    .out_valid(vout.valid), .sx(vout.screen_x), .sy(vout.screen_y),
    .behind(vout.behind_eye)
  );
endmodule
